/* design/lae_pkg.sv */
`default_nettype none

package lae_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_ATTACK  = 2'd0;
	localparam logic [1:0] CFG_DECAY   = 2'd1;
	localparam logic [1:0] CFG_SUSTAIN = 2'd2;
	localparam logic [1:0] CFG_RELEASE = 2'd3;

	localparam logic [15:0] ATTACK_RST  = 16'd10;
	localparam logic [15:0] DECAY_RST   = 16'd100;
	localparam logic [3:0]  SUSTAIN_RST = 4'd7;
	localparam logic [15:0] RELEASE_RST = 16'd200;

	localparam logic [3:0] SUSTAIN_MAX = 4'd10;

	// level = round(v * X * 32768 / (1270 * T)); half of 1270 is 635
	localparam logic [10:0] DEN_K  = 11'd1270;
	localparam logic [9:0]  HALF_K = 10'd635;

	localparam int QUO_W  = 16;
	localparam int NUM_W  = 43;
	localparam int DEN_W  = 27;
	localparam int SIDE_W = 17;

	localparam logic [15:0] LEVEL_MAX = 16'd32768;

	typedef enum logic [2:0] {
		PH_ATTACK,
		PH_DECAY,
		PH_SUSTAIN,
		PH_RELEASE,
		PH_DONE
	} phase_t;

endpackage

`default_nettype wire

/* design/lae_div.sv */
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num < den << QW.
module lae_div #(
	parameter int QW = 16,
	parameter int NW = 43,
	parameter int DW = 27,
	parameter int SW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [QW-1:0]      out_quo,
	output logic [SW-1:0]      out_side
);

	logic          vld_s  [QW];
	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic          src_v;
		logic [NW-1:0] src_rem;
		logic [DW-1:0] src_den;
		logic [QW-1:0] src_quo;
		logic [SW-1:0] src_side;
		logic [NW-1:0] shifted;
		logic          ge;
		logic [QW-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign src_v    = in_valid;
			assign src_rem  = in_num;
			assign src_den  = in_den;
			assign src_quo  = '0;
			assign src_side = in_side;
		end else begin : g_next
			assign src_v    = vld_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_quo  = quo_s[k-1];
			assign src_side = side_s[k-1];
		end

		always_comb begin
			shifted   = NW'(src_den) << B;
			ge        = src_rem >= shifted;
			quo_nx    = src_quo;
			quo_nx[B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? src_rem - shifted : src_rem;
				den_s[k]  <= src_den;
				quo_s[k]  <= quo_nx;
				side_s[k] <= src_side;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

`default_nettype wire

/* design/linear_adsr_envelope_top.sv */
`default_nettype none

// Linear ADSR envelope. Each input beat carries a voice's tick stamps, its
// velocity and one Q1.15 sample; each output beat carries the envelope level
// (unsigned Q1.15, 32768 = 1.0), the sample scaled by it and a done flag.
// Level = round(velocity * X * 32768 / (1270 * T)), where X and T depend on
// the phase; that quotient runs through a 16-stage bit-per-stage divider.
// Each beat passes six front stages, sixteen divider stages, two scaling
// stages and the output register. A two-entry output (register plus skid)
// lets the input keep flowing while one result waits; a new beat is taken
// every cycle until the skid is full, when the whole pipeline holds.
// Configuration must be written only while the block is idle (not enforced).
module linear_adsr_envelope_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [15:0]  cfg_wdata,
	// input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: now_tick[31:0], start_tick[63:32], release_tick[95:64],
	//        velocity[102:96], sample_in[118:103], zero pad[119]
	input  wire logic [119:0] s_axis_tdata,
	// tuser: is_released[0]
	input  wire logic [0:0]   s_axis_tuser,
	// output stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: level[15:0], sample_out[31:16]
	output logic [31:0]       m_axis_tdata,
	// tuser: voice_done[0]
	output logic [0:0]        m_axis_tuser
);

	import lae_pkg::*;

	// ---------------- configuration registers ----------------
	logic [15:0] attack_q, decay_q, release_q;
	logic [3:0]  sustain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ATTACK:  attack_q  <= cfg_wdata;
				CFG_DECAY:   decay_q   <= cfg_wdata;
				CFG_SUSTAIN: sustain_q <= cfg_wdata[3:0];
				CFG_RELEASE: release_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [3:0] sus_sat;
	assign sus_sat = (sustain_q > SUSTAIN_MAX) ? SUSTAIN_MAX : sustain_q;

	// global advance: the pipe moves unless the skid holds a beat
	logic sk_valid_q;
	logic en;
	assign en            = !sk_valid_q;
	assign s_axis_tready = en;

	// ---------------- s1: tick differences ----------------
	logic               v_s1, rel_s1;
	logic [31:0]        el_s1, rel_el_s1;
	logic [6:0]         vel_s1;
	logic signed [15:0] smp_s1;

	// ---------------- s2: phase select ----------------
	logic               v_s2;
	phase_t             ph_s2;
	logic [15:0]        op_s2;
	logic [6:0]         vel_s2;
	logic signed [15:0] smp_s2;

	// ---------------- s3: X terms and T ----------------
	logic               v_s3, done_s3;
	logic [19:0]        xa_s3, xb_s3;
	logic [15:0]        t_s3;
	logic [6:0]         vel_s3;
	logic signed [15:0] smp_s3;

	// ---------------- s4: X ----------------
	logic               v_s4, done_s4;
	logic [19:0]        x_s4;
	logic [15:0]        t_s4;
	logic [6:0]         vel_s4;
	logic signed [15:0] smp_s4;

	// ---------------- s5: products ----------------
	logic               v_s5, done_s5;
	logic [26:0]        vx_s5;
	logic [25:0]        hh_s5;
	logic [DEN_W-1:0]   dd_s5;
	logic signed [15:0] smp_s5;

	// ---------------- s6: rounded numerator ----------------
	logic               v_s6, done_s6;
	logic [NUM_W-1:0]   num_s6;
	logic [DEN_W-1:0]   dd_s6;
	logic signed [15:0] smp_s6;

	// s2 decode
	phase_t      ph_nx;
	logic [15:0] op_nx;
	always_comb begin
		ph_nx = PH_SUSTAIN;
		op_nx = '0;
		if (rel_s1) begin
			if (rel_el_s1 >= {16'd0, release_q}) begin
				ph_nx = PH_DONE;
			end else begin
				ph_nx = PH_RELEASE;
				op_nx = release_q - rel_el_s1[15:0];
			end
		end else if (el_s1 < {16'd0, attack_q}) begin
			ph_nx = PH_ATTACK;
			op_nx = el_s1[15:0];
		end else if (el_s1 < {15'd0, 17'(attack_q) + 17'(decay_q)}) begin
			ph_nx = PH_DECAY;
			op_nx = el_s1[15:0] - attack_q;
		end
	end

	// s3 decode
	logic [19:0] xa_nx, xb_nx;
	logic [15:0] t_nx;
	always_comb begin
		xa_nx = '0;
		xb_nx = '0;
		t_nx  = 16'd1;
		case (ph_s2)
			PH_ATTACK: begin
				xa_nx = 20'(op_s2) * 20'd10;
				t_nx  = attack_q;
			end
			PH_DECAY: begin
				// 10*d - (10-s)*de
				xa_nx = 20'(decay_q) * 20'd10;
				xb_nx = 20'(op_s2) * 20'(SUSTAIN_MAX - sus_sat);
				t_nx  = decay_q;
			end
			PH_SUSTAIN: begin
				xa_nx = 20'(sus_sat);
			end
			PH_RELEASE: begin
				xa_nx = 20'(op_s2) * 20'(sus_sat);
				t_nx  = release_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			el_s1     <= s_axis_tdata[31:0] - s_axis_tdata[63:32];
			rel_el_s1 <= s_axis_tdata[31:0] - s_axis_tdata[95:64];
			rel_s1    <= s_axis_tuser[0];
			vel_s1    <= s_axis_tdata[102:96];
			smp_s1    <= s_axis_tdata[118:103];

			ph_s2  <= ph_nx;
			op_s2  <= op_nx;
			vel_s2 <= vel_s1;
			smp_s2 <= smp_s1;

			xa_s3   <= xa_nx;
			xb_s3   <= xb_nx;
			t_s3    <= t_nx;
			done_s3 <= (ph_s2 == PH_DONE);
			vel_s3  <= vel_s2;
			smp_s3  <= smp_s2;

			x_s4    <= xa_s3 - xb_s3;
			t_s4    <= t_s3;
			done_s4 <= done_s3;
			vel_s4  <= vel_s3;
			smp_s4  <= smp_s3;

			vx_s5   <= 27'(vel_s4) * 27'(x_s4);
			hh_s5   <= 26'(t_s4) * 26'(HALF_K);
			dd_s5   <= DEN_W'(t_s4) * DEN_W'(DEN_K);
			done_s5 <= done_s4;
			smp_s5  <= smp_s4;

			num_s6  <= {1'b0, vx_s5, 15'd0} + NUM_W'(hh_s5);
			dd_s6   <= dd_s5;
			done_s6 <= done_s5;
			smp_s6  <= smp_s5;
		end
	end

	// ---------------- divider ----------------
	logic              dv_valid;
	logic [QUO_W-1:0]  dv_quo;
	logic [SIDE_W-1:0] dv_side;

	lae_div #(
		.QW(QUO_W),
		.NW(NUM_W),
		.DW(DEN_W),
		.SW(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.in_num   (num_s6),
		.in_den   (dd_s6),
		.in_side  ({done_s6, smp_s6}),
		.out_valid(dv_valid),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// ---------------- s7: sample scaling ----------------
	logic               v_s7, done_s7;
	logic [15:0]        lvl_s7;
	logic signed [32:0] prod_s7;
	logic [15:0]        lvl_c;
	assign lvl_c = (dv_quo > LEVEL_MAX) ? LEVEL_MAX : dv_quo;

	// ---------------- s8: round and saturate ----------------
	logic               v_s8, done_s8;
	logic [15:0]        lvl_s8;
	logic signed [15:0] so_s8;
	logic signed [33:0] p_rnd;
	logic signed [18:0] q_sh;
	logic signed [15:0] q_sat;
	always_comb begin
		p_rnd = 34'(prod_s7) + 34'sd16384;
		q_sh  = 19'(p_rnd >>> 15);
		if (q_sh > 19'sd32767) begin
			q_sat = 16'sh7fff;
		end else if (q_sh < -19'sd32768) begin
			q_sat = 16'sh8000;
		end else begin
			q_sat = q_sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s7 <= dv_valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s7  <= lvl_c;
			done_s7 <= dv_side[16];
			prod_s7 <= $signed(dv_side[15:0]) * $signed({1'b0, lvl_c});

			lvl_s8  <= lvl_s7;
			done_s8 <= done_s7;
			so_s8   <= q_sat;
		end
	end

	// ---------------- output register and skid ----------------
	logic [32:0] sk_data_q;
	logic [32:0] out_data_q;
	logic        out_valid_q;
	logic        out_free;
	assign out_free = m_axis_tready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_free) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= v_s8;
			end
		end else if (v_s8 && en) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= sk_valid_q ? sk_data_q : {done_s8, so_s8, lvl_s8};
		end else if (v_s8 && en) begin
			sk_data_q <= {done_s8, so_s8, lvl_s8};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q[31:0];
	assign m_axis_tuser  = out_data_q[32];

`ifndef ASSERT_OFF
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid filled without output stall");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[15:0] <= LEVEL_MAX))
		else $error("level above unity");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[32]) |-> (out_data_q[31:0] == 32'd0))
		else $error("finished voice with nonzero output");
`endif

endmodule

`default_nettype wire
